/* design/iir_df2t_pkg.sv */
package iir_df2t_pkg;

  localparam int MAX_ORDER      = 6;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 24;
  localparam int COEF_BITS      = 32;
  localparam int DELAY_BITS     = SAMPLE_BITS + COEF_FRAC_BITS;
  localparam int PROD_W         = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W          = PROD_W + 2;
  localparam int IDX_BITS       = 3;
  localparam int ORD_BITS       = 3;
  localparam int ACT_BITS       = 2;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_NUM    = 2'd1,
    ACT_DEN    = 2'd2,
    ACT_DELAY  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_B,
    ST_ACC,
    ST_MUL_A,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic wr_b;
    logic wr_a;
    logic wr_z;
    logic mul_b;
    logic mul_a;
    logic upd;
  } cell_ctrl_t;

  localparam logic signed [ACC_W-1:0] DELAY_MAX = ACC_W'((64'sd1 <<< (DELAY_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] DELAY_MIN = -DELAY_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SMP_MAX   = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SMP_MIN   = -SMP_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));

  function automatic logic [DELAY_BITS-1:0] clamp_delay(input logic signed [ACC_W-1:0] v);
    logic [DELAY_BITS-1:0] r;
    if (v > DELAY_MAX) begin
      r = DELAY_MAX[DELAY_BITS-1:0];
    end else if (v < DELAY_MIN) begin
      r = DELAY_MIN[DELAY_BITS-1:0];
    end else begin
      r = v[DELAY_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] clamp_sample(input logic signed [ACC_W-1:0] v);
    logic [SAMPLE_BITS-1:0] r;
    if (v > SMP_MAX) begin
      r = SMP_MAX[SAMPLE_BITS-1:0];
    end else if (v < SMP_MIN) begin
      r = SMP_MIN[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

/* design/iir_df2t_cell.sv */
module iir_df2t_cell
  import iir_df2t_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  cell_ctrl_t                    ctrl,
  input  logic signed [COEF_BITS-1:0]   coef,
  input  logic signed [DELAY_BITS-1:0]  delay_word,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] y,
  input  logic signed [DELAY_BITS-1:0]  z_in,
  output logic signed [DELAY_BITS-1:0]  z_out,
  output logic                          clip
);

  logic signed [COEF_BITS-1:0]  b;
  logic signed [COEF_BITS-1:0]  a;
  logic signed [DELAY_BITS-1:0] z;
  logic signed [PROD_W-1:0]     pb;
  logic signed [PROD_W-1:0]     pa;
  logic signed [ACC_W-1:0]      t;

  assign t     = ACC_W'(z_in) + ACC_W'(pb) - ACC_W'(pa);
  assign clip  = (t > DELAY_MAX) || (t < DELAY_MIN);
  assign z_out = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      b <= '0;
      a <= '0;
      z <= '0;
    end else begin
      if (ctrl.wr_b) begin
        b <= coef;
      end
      if (ctrl.wr_a) begin
        a <= coef;
      end
      if (ctrl.wr_z) begin
        z <= delay_word;
      end else if (ctrl.upd) begin
        z <= clamp_delay(t);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_b) begin
      pb <= PROD_W'(b) * PROD_W'(x);
    end
    if (ctrl.mul_a) begin
      pa <= PROD_W'(a) * PROD_W'(y);
    end
  end

endmodule

/* design/iir_df2t_head.sv */
module iir_df2t_head
  import iir_df2t_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_b0,
  input  logic                          mul_en,
  input  logic                          acc_en,
  input  logic signed [COEF_BITS-1:0]   coef,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [DELAY_BITS-1:0]  z0,
  output logic signed [SAMPLE_BITS-1:0] y,
  output logic                          y_clip
);

  logic signed [COEF_BITS-1:0] b0;
  logic signed [PROD_W-1:0]    p0;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     acc_sh;

  assign acc    = ACC_W'(z0) + ACC_W'(p0) + ROUND_HALF;
  assign acc_sh = acc >>> COEF_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0 <= '0;
    end else if (wr_b0) begin
      b0 <= coef;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      p0 <= PROD_W'(b0) * PROD_W'(x);
    end
    if (acc_en) begin
      y      <= clamp_sample(acc_sh);
      y_clip <= (acc_sh > SMP_MAX) || (acc_sh < SMP_MIN);
    end
  end

endmodule

/* design/iir_filter_df2t.sv */
// Direct form II transposed IIR filter, order 1 to 6 set by cfg_data (0 acts as 1, 7 as 6).
// Requests with tuser 1 or 2 load a numerator or denominator coefficient (Q8.24) at the
// index in tdata, tuser 3 loads one delay word (Q24.24); each returns nothing. A sample
// request (tuser 0) is registered at acceptance and returns one result after numerator
// products, accumulate and round, feedback products and a delay update that waits for the
// result register to be free. Each step feeds the next, so one sample is in flight at a
// time and the next request is taken the cycle after the delay line is updated. The
// result register frees the input side while a result waits; a further sample holds its
// delay update until that result is taken. The output and every delay word saturate;
// m_tuser flags it.
module iir_filter_df2t
  import iir_df2t_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // index, sample_in, coefficient, delay_word, zero pad
  input  logic [1:0]   s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [23:0]  m_tdata,   // sample_out
  output logic         m_tuser,   // saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_data   // filter_order
);

  state_t state;
  state_t state_next;

  logic [IDX_BITS-1:0]          idx;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic signed [COEF_BITS-1:0]   in_coef;
  logic signed [DELAY_BITS-1:0]  in_delay;
  logic                          accept;
  logic                          out_free;
  logic                          mul_b_en;
  logic                          acc_en;
  logic                          mul_a_en;
  logic                          upd_go;
  logic [ORD_BITS-1:0]           filter_order;
  logic [ORD_BITS-1:0]           order_eff;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] y;
  logic                          y_clip;
  logic signed [DELAY_BITS-1:0]  z [MAX_ORDER];
  logic signed [DELAY_BITS-1:0]  z_in [MAX_ORDER];
  logic [MAX_ORDER-1:0]          cell_clip;
  logic [MAX_ORDER-1:0]          active;
  cell_ctrl_t                    ctrl [MAX_ORDER];

  assign idx       = s_tdata[2:0];
  assign in_sample = s_tdata[26:3];
  assign in_coef   = s_tdata[58:27];
  assign in_delay  = s_tdata[106:59];

  assign s_tready  = (state == ST_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    if (filter_order == '0) begin
      order_eff = ORD_BITS'(1);
    end else if (filter_order > ORD_BITS'(MAX_ORDER)) begin
      order_eff = ORD_BITS'(MAX_ORDER);
    end else begin
      order_eff = filter_order;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= ORD_BITS'(2);
    end else if (cfg_valid && cfg_ready) begin
      filter_order <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && s_tuser == ACT_SAMPLE) begin
          state_next = ST_MUL_B;
        end
      end
      ST_MUL_B:  state_next = ST_ACC;
      ST_ACC:    state_next = ST_MUL_A;
      ST_MUL_A:  state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_b_en = 1'b0;
    acc_en   = 1'b0;
    mul_a_en = 1'b0;
    upd_go   = 1'b0;
    unique case (state)
      ST_IDLE:   ;
      ST_MUL_B:  mul_b_en = 1'b1;
      ST_ACC:    acc_en   = 1'b1;
      ST_MUL_A:  mul_a_en = 1'b1;
      ST_UPDATE: upd_go   = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser == ACT_SAMPLE) begin
      x <= in_sample;
    end
  end

  iir_df2t_head u_head (
    .clk    (clk),
    .rst    (rst),
    .wr_b0  (accept && s_tuser == ACT_NUM && idx == '0),
    .mul_en (mul_b_en),
    .acc_en (acc_en),
    .coef   (in_coef),
    .x      (x),
    .z0     (z[0]),
    .y      (y),
    .y_clip (y_clip)
  );

  for (genvar j = 0; j < MAX_ORDER; j++) begin : g_cell
    assign active[j] = ORD_BITS'(j) < order_eff;

    if (j == MAX_ORDER - 1) begin : g_last
      assign z_in[j] = '0;
    end else begin : g_mid
      assign z_in[j] = (ORD_BITS'(j + 1) < order_eff) ? z[j+1] : '0;
    end

    assign ctrl[j].wr_b  = accept && s_tuser == ACT_NUM && idx == IDX_BITS'(j + 1);
    assign ctrl[j].wr_a  = accept && s_tuser == ACT_DEN && idx == IDX_BITS'(j + 1);
    assign ctrl[j].wr_z  = accept && s_tuser == ACT_DELAY && idx == IDX_BITS'(j);
    assign ctrl[j].mul_b = mul_b_en;
    assign ctrl[j].mul_a = mul_a_en;
    assign ctrl[j].upd   = upd_go && active[j];

    iir_df2t_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl[j]),
      .coef       (in_coef),
      .delay_word (in_delay),
      .x          (x),
      .y          (y),
      .z_in       (z_in[j]),
      .z_out      (z[j]),
      .clip       (cell_clip[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (upd_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      m_tdata <= y;
      m_tuser <= y_clip || |(cell_clip & active);
    end
  end

`ifndef SYNTHESIS
  a_result_after_update: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_UPDATE))
    else $error("result appeared without a delay update");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && m_tvalid && !m_tready) |=> (state == ST_UPDATE))
    else $error("delay update ran while result register was full");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == ACT_SAMPLE) |=> (state == ST_MUL_B))
    else $error("accepted sample did not start");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser != ACT_SAMPLE) |=> (state == ST_IDLE))
    else $error("write request left idle");

  a_order_range: assert property (@(posedge clk) disable iff (rst)
    (order_eff >= ORD_BITS'(1)) && (order_eff <= ORD_BITS'(MAX_ORDER)))
    else $error("effective order out of range");
`endif

endmodule
